// ===== rtl/core/spq_pkg.sv =====
// Package for the sorted priority queue: widths, depth, status codes and
// the entry and control structs shared by the cell and the top level.
// Depends on nothing.
package spq_pkg;

    localparam int DEPTH       = 16;
    localparam int LEVEL_W     = 8;
    localparam int TAG_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic               ins;
        logic               pop;
        logic [LEVEL_W-1:0] level;
        logic [TAG_W-1:0]   tag;
    } t_ctl;

    localparam t_entry ENTRY_NONE = '{valid: 1'b0, level: '0, tag: '0};

endpackage

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted priority queue: a chain of DEPTH cells kept in service order, cell 0
// at the head (highest level, oldest among equals), and one result register.
// Takes one request per clock: every cell compares the request against its own
// entry in parallel and trades with a neighbor in the same edge, so an insert
// or a pop updates the cells at the same edge that loads its result register; the only
// stall comes from the result register while the downstream side holds tready
// low. A request waits only for that register. Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [0] operation, [8:1] level, [24:9] tag, rest zero
    input  logic [spq_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [15:0] out_tag, [23:16] out_level, [25:24] status, rest zero
    output logic [spq_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int LW = spq_pkg::LEVEL_W;
    localparam int TW = spq_pkg::TAG_W;
    localparam int SW = spq_pkg::STATUS_W;

    logic                 w_op;
    logic [LW-1:0]        w_level;
    logic [TW-1:0]        w_tag;
    logic                 w_acc;
    logic                 w_full;
    logic                 w_empty;
    spq_pkg::t_ctl        w_ctl;
    spq_pkg::t_entry      w_entry [DEPTH];
    logic [DEPTH-1:0]     w_ge;
    logic [DEPTH-1:0]     w_vld;

    logic                 r_out_valid;
    logic [TW-1:0]        r_out_tag;
    logic [LW-1:0]        r_out_level;
    logic [SW-1:0]        r_out_status;
    logic [TW-1:0]        n_out_tag;
    logic [LW-1:0]        n_out_level;
    logic [SW-1:0]        n_out_status;

    assign w_op    = i_s_tdata[0];
    assign w_level = i_s_tdata[LW:1];
    assign w_tag   = i_s_tdata[LW+TW:LW+1];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_full     = w_vld[DEPTH-1];
    assign w_empty    = !w_vld[0];

    assign w_ctl.ins   = w_acc && (w_op == spq_pkg::OP_ENQ) && !w_full;
    assign w_ctl.pop   = w_acc && (w_op == spq_pkg::OP_DEQ) && !w_empty;
    assign w_ctl.level = w_level;
    assign w_ctl.tag   = w_tag;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_pkg::t_entry w_prev;
        spq_pkg::t_entry w_next;
        logic            w_prev_ge;

        if (g == 0) begin : g_head
            assign w_prev    = spq_pkg::ENTRY_NONE;
            assign w_prev_ge = 1'b1;
        end else begin : g_body
            assign w_prev    = w_entry[g-1];
            assign w_prev_ge = w_ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = spq_pkg::ENTRY_NONE;
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_prev    (w_prev),
            .i_prev_ge (w_prev_ge),
            .i_next    (w_next),
            .o_entry   (w_entry[g]),
            .o_ge      (w_ge[g])
        );

        assign w_vld[g] = w_entry[g].valid;
    end

    always_comb begin
        n_out_tag    = '0;
        n_out_level  = '0;
        n_out_status = spq_pkg::ST_ENQUEUED;
        if (w_op == spq_pkg::OP_ENQ) begin
            if (w_full) begin
                n_out_status = spq_pkg::ST_FULL;
            end
        end else if (w_empty) begin
            n_out_status = spq_pkg::ST_EMPTY;
        end else begin
            n_out_tag    = w_entry[0].tag;
            n_out_level  = w_entry[0].level;
            n_out_status = spq_pkg::ST_DEQUEUED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_acc) begin
            r_out_tag    <= n_out_tag;
            r_out_level  <= n_out_level;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(spq_pkg::OUT_TDATA_W - TW - LW - SW){1'b0}},
                         r_out_status, r_out_level, r_out_tag};

    // Occupied cells form an unbroken run from the head.
    a_vld_prefix : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld & (w_vld + 1'b1)) == '0)
        else $error("occupied cells not contiguous from the head");

    // Head cell never holds a lower level than the cell behind it.
    a_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[1] |-> (w_entry[0].level >= w_entry[1].level))
        else $error("cells out of level order");

    // An enqueue that fits grows the occupancy by exactly one.
    a_enq_grow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> ($countones(w_vld) == $past($countones(w_vld)) + 1))
        else $error("enqueue did not add exactly one entry");

    // A pop returns the head entry's tag in the next result and shrinks the occupancy by one.
    a_pop_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> (r_out_status == spq_pkg::ST_DEQUEUED
                       && r_out_tag == $past(w_entry[0].tag)
                       && $countones(w_vld) + 1 == $past($countones(w_vld))))
        else $error("dequeue result does not match head entry");

endmodule

// ===== rtl/core/spq_cell.sv =====
// One cell of the queue chain: holds one entry, keeps it, takes the new
// entry, or takes a neighbor's entry on insert or pop. Depends on spq_pkg.
module spq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spq_pkg::t_ctl   i_ctl,
    input  spq_pkg::t_entry i_prev,
    input  logic            i_prev_ge,
    input  spq_pkg::t_entry i_next,
    output spq_pkg::t_entry o_entry,
    output logic            o_ge
);

    logic                        r_valid;
    logic [spq_pkg::LEVEL_W-1:0] r_level;
    logic [spq_pkg::TAG_W-1:0]   r_tag;
    logic                        n_valid;
    logic [spq_pkg::LEVEL_W-1:0] n_level;
    logic [spq_pkg::TAG_W-1:0]   n_tag;

    assign o_ge    = r_valid && (r_level >= i_ctl.level);
    assign o_entry = '{valid: r_valid, level: r_level, tag: r_tag};

    always_comb begin
        n_valid = r_valid;
        n_level = r_level;
        n_tag   = r_tag;
        if (i_ctl.pop) begin
            n_valid = i_next.valid;
            n_level = i_next.level;
            n_tag   = i_next.tag;
        end else if (i_ctl.ins && !o_ge) begin
            if (i_prev_ge) begin
                n_valid = 1'b1;
                n_level = i_ctl.level;
                n_tag   = i_ctl.tag;
            end else begin
                n_valid = i_prev.valid;
                n_level = i_prev.level;
                n_tag   = i_prev.tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_level <= n_level;
        r_tag   <= n_tag;
    end

endmodule

// ===== sim/tb_sorted_priority_queue_top.sv =====
// Testbench for sorted_priority_queue_top: directed and random enqueue and
// dequeue requests checked against a service-order model kept in the bench.
// Depends on spq_pkg and the sorted_priority_queue_top RTL.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_top;

    typedef struct packed {
        logic [spq_pkg::LEVEL_W-1:0] level;
        logic [spq_pkg::TAG_W-1:0]   tag;
    } t_held_entry;

    typedef struct packed {
        logic [spq_pkg::TAG_W-1:0]    tag;
        logic [spq_pkg::LEVEL_W-1:0]  level;
        logic [spq_pkg::STATUS_W-1:0] status;
    } t_queue_result;

    typedef enum int {BURST_FILL, BURST_DRAIN, BURST_CHURN} t_burst_kind;

    localparam int LEVEL_W     = spq_pkg::LEVEL_W;
    localparam int TAG_W       = spq_pkg::TAG_W;
    localparam int STATUS_W    = spq_pkg::STATUS_W;
    localparam int IN_TDATA_W  = spq_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = spq_pkg::OUT_TDATA_W;
    localparam int PAD_LSB     = TAG_W + LEVEL_W + STATUS_W;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    t_held_entry   held_entries[$];     // service order: index 0 leaves first
    t_queue_result pending_results[$];
    t_queue_result next_result;
    int            mismatch_count = 0;
    int            src_idle_pct   = 0;
    int            snk_stall_pct  = 0;

    sorted_priority_queue_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t ns %s: got %h want %h", $time, what, got, want);
    endtask

    function automatic t_queue_result apply_request(input logic op,
                                                    input logic [LEVEL_W-1:0] lvl,
                                                    input logic [TAG_W-1:0] tg);
        t_queue_result r;
        t_held_entry   e;
        int            pos;
        r = '{tag: '0, level: '0, status: spq_pkg::ST_ENQUEUED};
        e = '{level: lvl, tag: tg};
        if (op == spq_pkg::OP_ENQ) begin
            if (held_entries.size() >= spq_pkg::DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                // go behind every entry of equal or higher level
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].level >= lvl)
                    pos++;
                held_entries.insert(pos, e);
            end
        end else if (held_entries.size() == 0) begin
            r.status = spq_pkg::ST_EMPTY;
        end else begin
            r.tag    = held_entries[0].tag;
            r.level  = held_entries[0].level;
            r.status = spq_pkg::ST_DEQUEUED;
            held_entries.delete(0);
        end
        return r;
    endfunction

    task automatic send_request(input logic op, input logic [LEVEL_W-1:0] lvl,
                                input logic [TAG_W-1:0] tg);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - TAG_W - LEVEL_W - 1){1'b0}}, tg, lvl, op};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(apply_request(op, lvl, tg));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", o_m_tdata, '0);
            end else begin
                next_result = pending_results.pop_front();
                if (o_m_tdata[TAG_W-1:0] !== next_result.tag)
                    report_mismatch("out_tag", 32'(o_m_tdata[TAG_W-1:0]),
                                    32'(next_result.tag));
                if (o_m_tdata[TAG_W +: LEVEL_W] !== next_result.level)
                    report_mismatch("out_level", 32'(o_m_tdata[TAG_W +: LEVEL_W]),
                                    32'(next_result.level));
                if (o_m_tdata[TAG_W + LEVEL_W +: STATUS_W] !== next_result.status)
                    report_mismatch("status", 32'(o_m_tdata[TAG_W + LEVEL_W +: STATUS_W]),
                                    32'(next_result.status));
                if (o_m_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0)
                    report_mismatch("padding", 32'(o_m_tdata[OUT_TDATA_W-1:PAD_LSB]), '0);
            end
        end
    end

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(3))
            0: return LEVEL_W'($urandom_range(3));
            1: return $urandom_range(1) ? {LEVEL_W{1'b1}} : '0;
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    task automatic test_empty_dequeue();
        send_request(spq_pkg::OP_DEQ, '0, '0);
        send_request(spq_pkg::OP_DEQ, {LEVEL_W{1'b1}}, {TAG_W{1'b1}});
    endtask

    task automatic test_level_extremes_and_ties();
        send_request(spq_pkg::OP_ENQ, 8'h00, 16'h0000);
        send_request(spq_pkg::OP_ENQ, 8'hff, 16'hffff);
        send_request(spq_pkg::OP_ENQ, 8'hff, 16'h1234);
        send_request(spq_pkg::OP_ENQ, 8'h00, 16'habcd);
        send_request(spq_pkg::OP_DEQ, 8'h5a, 16'hc3c3);
        send_request(spq_pkg::OP_DEQ, 8'h00, 16'h0000);
        send_request(spq_pkg::OP_DEQ, 8'hff, 16'hffff);
        send_request(spq_pkg::OP_DEQ, 8'h00, 16'h0000);
        send_request(spq_pkg::OP_DEQ, 8'h00, 16'h0000);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < spq_pkg::DEPTH; i++)
            send_request(spq_pkg::OP_ENQ, LEVEL_W'((i * 37) % 5), TAG_W'(16'h8000 + i));
        send_request(spq_pkg::OP_ENQ, 8'hff, 16'hffff);
        send_request(spq_pkg::OP_DEQ, 8'h00, 16'h0000);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        t_burst_kind kind;
        int          burst_left;
        int          enq_pct;
        logic        op;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        burst_left    = 0;
        enq_pct       = 50;
        for (int i = 0; i < n_items; i++) begin
            if (burst_left == 0) begin
                kind       = t_burst_kind'($urandom_range(2));
                burst_left = $urandom_range(24, 1);
                case (kind)
                    BURST_FILL:  enq_pct = 85;
                    BURST_DRAIN: enq_pct = 15;
                    default:     enq_pct = 50;
                endcase
            end
            burst_left--;
            op = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
            send_request(op, pick_level(), TAG_W'($urandom));
        end
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", pending_results.size(), '0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_dequeue();
        test_level_extremes_and_ties();
        test_full_queue();
        test_random_traffic(500, 0, 0);
        test_random_traffic(500, 59, 0);
        test_random_traffic(500, 0, 59);
        test_random_traffic(500, 31, 31);
        wait_for_results();

        if (mismatch_count == 0)
            $display("sorted_priority_queue_top: match");
        else
            $display("sorted_priority_queue_top: mismatch");
        $finish;
    end

    initial begin
        #4000000;
        $display("sorted_priority_queue_top: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_top.sv
sim/tb_sorted_priority_queue_top.sv
